[design/wdds_pkg.sv]
// ----------------------------------------------------------------------------
// wdds_pkg - shared types and constants of the wavetable oscillator
// Table geometry, phase format, output scaling and command codes.
// ----------------------------------------------------------------------------
package wdds_pkg;

  // Table and phase geometry
  localparam int TABLE_DEPTH   = 1000;
  localparam int FRACTION_BITS = 16;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  localparam int PHASE_W       = ADDR_W + FRACTION_BITS;

  // Fixed field widths
  localparam int CMD_W    = 2;
  localparam int INDEX_W  = 10;
  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 26;
  localparam int GAIN_W   = 16;
  localparam int LEVEL_W  = 12;
  localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;

  // Stream packing
  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 16;

  // Output scaling
  localparam int GAIN_SHIFT   = 17;
  localparam int LEVEL_OFFSET = 1200;
  localparam int LEVEL_MAX    = 4095;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(2048);

  // Phase wraps at the table span
  localparam logic [PHASE_W:0] SPAN =
    (PHASE_W+1)'(longint'(TABLE_DEPTH) << FRACTION_BITS);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_e;

  // Stage enables of the output pipe
  typedef struct packed {
    logic s2_en;
    logic out_en;
  } pipe_ctrl_t;

endpackage

[design/wdds_phase.sv]
// ----------------------------------------------------------------------------
// wdds_phase - phase step and phase accumulator
// Advance the phase by the step on a tick and wrap once at the table span.
// ----------------------------------------------------------------------------
module wdds_phase (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     advance_i,
  input  logic                                     load_i,
  input  logic [wdds_pkg::STEP_W-1:0]              step_value_i,
  output logic [wdds_pkg::ADDR_W-1:0]              slot_o,
  output logic [wdds_pkg::PHASE_W-1:0]             phase_o,
  output logic [wdds_pkg::PHASE_W-1:0]             step_o
);

  logic [wdds_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [wdds_pkg::PHASE_W-1:0] step_q, step_d;
  logic [wdds_pkg::PHASE_W:0]   sum;
  logic [wdds_pkg::PHASE_W:0]   wrapped;
  logic [wdds_pkg::PHASE_W-1:0] phase_next;

  assign sum = {1'b0, phase_q} + {1'b0, step_q};

  always_comb begin
    wrapped = sum;
    if (sum[wdds_pkg::PHASE_W:wdds_pkg::FRACTION_BITS] >=
        (wdds_pkg::ADDR_W+1)'(wdds_pkg::TABLE_DEPTH)) begin
      wrapped = sum - wdds_pkg::SPAN;
    end
  end

  assign phase_next = wrapped[wdds_pkg::PHASE_W-1:0];
  assign slot_o     = phase_next[wdds_pkg::PHASE_W-1:wdds_pkg::FRACTION_BITS];

  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    if (advance_i) begin
      phase_d = phase_next;
    end else if (load_i) begin
      if (step_value_i == '0) begin
        // zero step stops the oscillator and clears the phase
        step_d  = '0;
        phase_d = '0;
      end else if (64'(step_value_i) >= 64'(wdds_pkg::SPAN)) begin
        step_d = wdds_pkg::PHASE_W'(wdds_pkg::SPAN - 1'b1);
      end else begin
        step_d = wdds_pkg::PHASE_W'(step_value_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      step_q  <= '0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
    end
  end

  assign phase_o = phase_q;
  assign step_o  = step_q;

endmodule

[design/wdds_table.sv]
// ----------------------------------------------------------------------------
// wdds_table - one-period sample table
// Single write port, one registered read port.
// ----------------------------------------------------------------------------
module wdds_table (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [wdds_pkg::ADDR_W-1:0]          waddr_i,
  input  logic signed [wdds_pkg::SAMPLE_W-1:0] wdata_i,
  input  logic                                 re_i,
  input  logic [wdds_pkg::ADDR_W-1:0]          raddr_i,
  output logic signed [wdds_pkg::SAMPLE_W-1:0] rdata_o
);

  logic signed [wdds_pkg::SAMPLE_W-1:0] mem_q [wdds_pkg::TABLE_DEPTH];
  logic signed [wdds_pkg::SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/wdds_level.sv]
// ----------------------------------------------------------------------------
// wdds_level - gain, offset and clamp
// Multiply the sample by the gain, then shift, offset and clamp to 12 bits.
// ----------------------------------------------------------------------------
module wdds_level (
  input  logic                                 clk_i,
  input  wdds_pkg::pipe_ctrl_t                 ctrl_i,
  input  logic signed [wdds_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [wdds_pkg::GAIN_W-1:0]          gain_i,
  output logic [wdds_pkg::LEVEL_W-1:0]         level_o
);

  localparam int SHIFTED_W = wdds_pkg::PROD_W - wdds_pkg::GAIN_SHIFT;
  localparam int SUM_W     = SHIFTED_W + 2;

  logic signed [wdds_pkg::PROD_W-1:0]  prod_q, prod_d;
  logic signed [SHIFTED_W-1:0]         shifted;
  logic signed [SUM_W-1:0]             biased;
  logic [wdds_pkg::LEVEL_W-1:0]        level_q, level_d;

  // widen both operands to the full product width before multiplying
  assign prod_d = wdds_pkg::PROD_W'(sample_i) *
                  wdds_pkg::PROD_W'($signed({1'b0, gain_i}));

  // floor shift: arithmetic shift of the signed product
  assign shifted = prod_q[wdds_pkg::PROD_W-1:wdds_pkg::GAIN_SHIFT];
  assign biased  = SUM_W'(shifted) + SUM_W'(wdds_pkg::LEVEL_OFFSET);

  always_comb begin
    if (biased < 0) begin
      level_d = '0;
    end else if (biased > SUM_W'(wdds_pkg::LEVEL_MAX)) begin
      level_d = wdds_pkg::LEVEL_W'(wdds_pkg::LEVEL_MAX);
    end else begin
      level_d = biased[wdds_pkg::LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s2_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.out_en) begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;

endmodule

[design/wavetable_dds_pwm_sample.sv]
// ----------------------------------------------------------------------------
// wavetable_dds_pwm_sample - wavetable oscillator feeding a PWM compare value
// Table load, phase step set and sample tick on one command stream.
// ----------------------------------------------------------------------------
// Path: a tick word passes the input register, then the table read, product
//   and output registers, before its pwm_level leaves the block.
// Throughput: one word per cycle; each stage holds only when the next is
//   full and stalled, so the input keeps flowing while a result waits.
// Reset (rst_ni low, asynchronous): phase and step clear, gain returns to
//   2048, all pipe valids drop; the sample table keeps its contents.
module wavetable_dds_pwm_sample (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration: gain
  input  logic                            cfg_we_i,
  input  logic [wdds_pkg::GAIN_W-1:0]     cfg_wdata_i,
  // input stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [9:0] table_index, [25:10] table_value, [51:26] step_value, [55:52] zero
  input  logic [wdds_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // [1:0] command
  input  logic [wdds_pkg::CMD_W-1:0]      s_axis_tuser_i,
  // output stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [11:0] pwm_level, [15:12] zero
  output logic [wdds_pkg::M_TDATA_W-1:0]  m_axis_tdata_o
);

  // Gain register; the user must write it only while the block is idle, the block does not enforce this
  logic [wdds_pkg::GAIN_W-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= wdds_pkg::GAIN_RESET;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  // Pipe valids and per-stage ready chain
  logic s0_v_q, s1_v_q, s2_v_q, out_v_q;
  logic r0, r1, r2, r_out;

  assign r_out = !out_v_q || m_axis_tready_i;
  assign r2    = !s2_v_q  || r_out;
  assign r1    = !s1_v_q  || r2;
  assign r0    = !s0_v_q  || r1;

  assign s_axis_tready_o = r0;

  // Input register: capture one word on acceptance
  logic [wdds_pkg::CMD_W-1:0]           s0_cmd_q;
  logic [wdds_pkg::INDEX_W-1:0]         s0_index_q;
  logic signed [wdds_pkg::SAMPLE_W-1:0] s0_value_q;
  logic [wdds_pkg::STEP_W-1:0]          s0_step_q;

  always_ff @(posedge clk_i) begin
    if (r0 && s_axis_tvalid_i) begin
      s0_cmd_q   <= s_axis_tuser_i;
      s0_index_q <= s_axis_tdata_i[9:0];
      s0_value_q <= s_axis_tdata_i[25:10];
      s0_step_q  <= s_axis_tdata_i[51:26];
    end
  end

  // Execute the held word as it leaves the input register
  logic s0_fire, do_tick, do_write, do_step, index_ok;

  assign s0_fire  = s0_v_q && r1;
  assign index_ok = 64'(s0_index_q) < 64'(wdds_pkg::TABLE_DEPTH);
  assign do_tick  = s0_fire && (s0_cmd_q == wdds_pkg::CMD_TICK);
  assign do_write = s0_fire && (s0_cmd_q == wdds_pkg::CMD_WRITE) && index_ok;
  assign do_step  = s0_fire && (s0_cmd_q == wdds_pkg::CMD_STEP);

  logic [wdds_pkg::ADDR_W-1:0]  slot;
  logic [wdds_pkg::PHASE_W-1:0] phase, step;

  wdds_phase u_phase (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (do_tick),
    .load_i       (do_step),
    .step_value_i (s0_step_q),
    .slot_o       (slot),
    .phase_o      (phase),
    .step_o       (step)
  );

  // Table read for a tick lands in the read register alongside s1
  logic signed [wdds_pkg::SAMPLE_W-1:0] sample;

  wdds_table u_table (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (wdds_pkg::ADDR_W'(s0_index_q)),
    .wdata_i (s0_value_q),
    .re_i    (do_tick),
    .raddr_i (slot),
    .rdata_o (sample)
  );

  // Product register (s2) and output register
  wdds_pkg::pipe_ctrl_t ctrl;
  logic [wdds_pkg::LEVEL_W-1:0] level;

  assign ctrl.s2_en  = r2 && s1_v_q;
  assign ctrl.out_en = r_out && s2_v_q;

  wdds_level u_level (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .sample_i (sample),
    .gain_i   (gain_q),
    .level_o  (level)
  );

  // Valid bits: only ticks travel past the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (r0) begin
        s0_v_q <= s_axis_tvalid_i;
      end
      if (r1) begin
        s1_v_q <= do_tick;
      end
      if (r2) begin
        s2_v_q <= s1_v_q;
      end
      if (r_out) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = wdds_pkg::M_TDATA_W'(level);

  // Phase stays inside the table after every wrap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    64'(phase) < 64'(wdds_pkg::SPAN))
    else $error("phase outside table span");

  // Saturated step never reaches the span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    64'(step) < 64'(wdds_pkg::SPAN))
    else $error("phase step not saturated");

  // Input stalls only when every stage is full and the output is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (s0_v_q && s1_v_q && s2_v_q && out_v_q && !m_axis_tready_i))
    else $error("input stalled with room in the pipe");

  // A tick leaving the input register occupies the read stage next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_tick |=> s1_v_q)
    else $error("tick lost after table read");

  // Non-tick commands produce no read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_fire && s0_cmd_q != wdds_pkg::CMD_TICK) |=> !s1_v_q)
    else $error("result created for non-tick command");

endmodule

[tb/sv/wavetable_dds_pwm_sample_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavetable_dds_pwm_sample_tb - self-checking bench of the wavetable oscillator
// Drive table loads, phase steps and sample ticks through the input stream.
// Predict every pwm_level word and compare it with the output stream.
// The sender idles in bursts and the receiver stalls in patterns of its own.
// ----------------------------------------------------------------------------
module wavetable_dds_pwm_sample_tb;

  // Command code that the block defines no operation for
  localparam logic [wdds_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Phase span of the table in 10.16 format (table depth << fraction bits)
  localparam int unsigned SPAN_U = wdds_pkg::TABLE_DEPTH << wdds_pkg::FRACTION_BITS;

  // Drain wait at the end of a phase; allow ample margin beyond a tick word's path through the block
  localparam int DRAIN_CYCLES = 8;
  // Bound on the wait for outstanding words at the end of a phase
  localparam int IDLE_LIMIT   = 4000;
  // Random words per gain setting
  localparam int PHASE_WORDS  = 280;

  typedef struct {
    logic [wdds_pkg::CMD_W-1:0]    cmd;
    logic [wdds_pkg::INDEX_W-1:0]  index;
    logic [wdds_pkg::SAMPLE_W-1:0] value;
    logic [wdds_pkg::STEP_W-1:0]   step;
    int                            level;   // typed-in pwm_level, or -1 for the predictor
  } stim_row_t;

  typedef enum int {RX_OPEN, RX_CHOPPY, RX_CHOKED} rx_mode_e;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [wdds_pkg::GAIN_W-1:0]    cfg_wdata_i = '0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [wdds_pkg::S_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic [wdds_pkg::CMD_W-1:0]     s_axis_tuser_i = wdds_pkg::CMD_TICK;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  logic [wdds_pkg::M_TDATA_W-1:0] m_axis_tdata_o;

  wavetable_dds_pwm_sample dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Oscillator predictor: its own copy of phase, step, table and gain
  // --------------------------------------------------------------------------
  longint unsigned osc_phase = 0;
  longint unsigned osc_step  = 0;
  logic [wdds_pkg::GAIN_W-1:0] osc_gain = wdds_pkg::GAIN_RESET;
  shortint wave_table [wdds_pkg::TABLE_DEPTH];
  bit      wave_written [wdds_pkg::TABLE_DEPTH];

  logic [wdds_pkg::LEVEL_W-1:0] pending_levels [$];
  int errors = 0;
  int row_level = -1;   // typed-in level of the word on the bus, -1 if none

  // Phase after one more tick: advance by the step and wrap once at the span.
  function automatic longint unsigned advanced_phase();
    longint unsigned p;
    p = osc_phase + osc_step;
    if ((p >> wdds_pkg::FRACTION_BITS) >= wdds_pkg::TABLE_DEPTH) p -= longint'(SPAN_U);
    return p;
  endfunction

  // Apply one accepted word to the predictor; return the level a tick gives.
  task automatic synth_word(input logic [wdds_pkg::CMD_W-1:0] cmd,
                            input logic [wdds_pkg::S_TDATA_W-1:0] data,
                            output bit produced,
                            output logic [wdds_pkg::LEVEL_W-1:0] level);
    logic [wdds_pkg::INDEX_W-1:0]  index;
    logic [wdds_pkg::SAMPLE_W-1:0] value;
    logic [wdds_pkg::STEP_W-1:0]   step;
    longint                        prod;
    longint                        lvl;
    index    = data[wdds_pkg::INDEX_W-1:0];
    value    = data[wdds_pkg::INDEX_W +: wdds_pkg::SAMPLE_W];
    step     = data[wdds_pkg::INDEX_W+wdds_pkg::SAMPLE_W +: wdds_pkg::STEP_W];
    produced = 1'b0;
    level    = '0;
    case (cmd)
      wdds_pkg::CMD_WRITE: begin
        // drop writes beyond the table
        if (index < wdds_pkg::TABLE_DEPTH) begin
          wave_table[index]   = shortint'(value);
          wave_written[index] = 1'b1;
        end
      end
      wdds_pkg::CMD_STEP: begin
        if (step == '0) begin
          // zero step stops the oscillator and clears the phase
          osc_step  = 0;
          osc_phase = 0;
        end else begin
          // saturate to one phase LSB short of the span
          osc_step = (step >= SPAN_U) ? longint'(SPAN_U) - 1 : longint'(step);
        end
      end
      wdds_pkg::CMD_TICK: begin
        osc_phase = advanced_phase();
        prod = longint'(wave_table[osc_phase >> wdds_pkg::FRACTION_BITS]) *
               longint'(osc_gain);
        lvl  = (prod >>> wdds_pkg::GAIN_SHIFT) + wdds_pkg::LEVEL_OFFSET;
        if (lvl > wdds_pkg::LEVEL_MAX) lvl = wdds_pkg::LEVEL_MAX;
        if (lvl < 0) lvl = 0;
        level    = wdds_pkg::LEVEL_W'(lvl);
        produced = 1'b1;
      end
      default: ;   // unused command: no effect, no word
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Scoreboard: check output words first, then predict the accepted input word
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bit                           produced;
    logic [wdds_pkg::LEVEL_W-1:0] level;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_levels.size() == 0) begin
          $error("pwm_level: no word expected, got %0d",
                 m_axis_tdata_o[wdds_pkg::LEVEL_W-1:0]);
          errors++;
        end else begin
          level = pending_levels.pop_front();
          if (m_axis_tdata_o[wdds_pkg::LEVEL_W-1:0] !== level) begin
            $error("pwm_level: expected %0d, got %0d", level,
                   m_axis_tdata_o[wdds_pkg::LEVEL_W-1:0]);
            errors++;
          end
          if (m_axis_tdata_o[wdds_pkg::M_TDATA_W-1:wdds_pkg::LEVEL_W] !== '0) begin
            $error("tdata pad: expected 0, got %0h",
                   m_axis_tdata_o[wdds_pkg::M_TDATA_W-1:wdds_pkg::LEVEL_W]);
            errors++;
          end
        end
      end
      if (cfg_we_i) osc_gain = cfg_wdata_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        synth_word(s_axis_tuser_i, s_axis_tdata_i, produced, level);
        if (produced) begin
          pending_levels.push_back(row_level >= 0 ? wdds_pkg::LEVEL_W'(row_level) : level);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: switch between open, choppy and choked stretches
  // --------------------------------------------------------------------------
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(2));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   m_axis_tready_i <= 1'b1;
      RX_CHOPPY: m_axis_tready_i <= 1'($urandom_range(1));
      default:   m_axis_tready_i <= ($urandom_range(3) == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  int burst_left = 0;

  // Draw one random word. Mostly ticks and table loads; a tick whose slot was
  // never loaded turns into a load of that slot, so no tick reads an empty entry.
  function automatic stim_row_t pick_word();
    stim_row_t       w;
    int              roll;
    longint unsigned nxt;
    w.cmd   = wdds_pkg::CMD_TICK;
    w.index = wdds_pkg::INDEX_W'($urandom);
    w.value = wdds_pkg::SAMPLE_W'($urandom);
    w.step  = wdds_pkg::STEP_W'($urandom);
    w.level = -1;
    roll = $urandom_range(99);
    if (roll < 50) begin
      nxt = advanced_phase();
      if (!wave_written[nxt >> wdds_pkg::FRACTION_BITS]) begin
        w.cmd   = wdds_pkg::CMD_WRITE;
        w.index = wdds_pkg::INDEX_W'(nxt >> wdds_pkg::FRACTION_BITS);
      end
    end else if (roll < 78) begin
      w.cmd   = wdds_pkg::CMD_WRITE;
      w.index = wdds_pkg::INDEX_W'($urandom_range(wdds_pkg::TABLE_DEPTH - 1));
      if ($urandom_range(9) == 0) w.value = $urandom_range(1) ? 16'h7FFF : 16'h8000;
    end else if (roll < 90) begin
      w.cmd = wdds_pkg::CMD_STEP;
      case ($urandom_range(9))
        0:       w.step = '0;
        1, 2, 3: w.step = wdds_pkg::STEP_W'($urandom_range(4 << wdds_pkg::FRACTION_BITS));
        4:       w.step = $urandom_range(1) ? wdds_pkg::STEP_W'(SPAN_U - 1)
                                            : wdds_pkg::STEP_W'(SPAN_U);
        5, 6:    ;   // full-width random step, seldom saturating
        default: w.step = wdds_pkg::STEP_W'($urandom_range(SPAN_U - 1));
      endcase
    end else if ($urandom_range(1)) begin
      w.cmd = CMD_UNUSED;
    end else begin
      // load beyond the table: must be dropped
      w.cmd   = wdds_pkg::CMD_WRITE;
      w.index = wdds_pkg::INDEX_W'($urandom_range(1023, wdds_pkg::TABLE_DEPTH));
    end
    return w;
  endfunction

  // Present one word (a table row, or a random one drawn at the falling edge),
  // then hold it until accepted. Entered just after a rising edge.
  task automatic send_word(input bit random_word, input stim_row_t row);
    stim_row_t w;
    int        gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      // one burst in four runs long with no gaps at all
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      repeat (gap) begin
        s_axis_tvalid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    burst_left--;
    w = random_word ? pick_word() : row;
    row_level = w.level;
    s_axis_tuser_i  <= w.cmd;
    s_axis_tdata_i  <= {4'b0, w.step, w.value, w.index};
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every expected word has come, then let the
  // pipe run dry of table loads and step updates as well.
  task automatic wait_idle();
    int n;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    for (n = 0; n < IDLE_LIMIT && pending_levels.size() != 0; n++) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Write the gain while the block is idle. Entered at a falling edge.
  task automatic load_gain(input logic [wdds_pkg::GAIN_W-1:0] gain);
    cfg_wdata_i <= gain;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Directed rows at the reset gain of 2048: full-scale samples give
  // 32767*2048>>17 + 1200 = 1711 and -32768*2048>>17 + 1200 = 688.
  // --------------------------------------------------------------------------
  localparam int DIRECTED_ROWS = 25;
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{wdds_pkg::CMD_WRITE, 10'd0,    16'h7FFF, 26'd0,        -1},
    '{wdds_pkg::CMD_WRITE, 10'd999,  16'h8000, 26'd0,        -1},
    '{wdds_pkg::CMD_WRITE, 10'd1,    16'h0000, 26'd0,        -1},
    '{wdds_pkg::CMD_WRITE, 10'd1000, 16'h1234, 26'd0,        -1},    // beyond the table
    '{wdds_pkg::CMD_WRITE, 10'd1023, 16'hFFFF, 26'd0,        -1},    // beyond the table
    '{wdds_pkg::CMD_TICK,  10'd0,    16'h0000, 26'd0,        1711},  // still at slot 0
    '{wdds_pkg::CMD_STEP,  10'd0,    16'h0000, 26'd65470464, -1},    // 999 slots per tick
    '{wdds_pkg::CMD_TICK,  10'd0,    16'h0000, 26'd0,        688},   // slot 999
    '{wdds_pkg::CMD_STEP,  10'd0,    16'h0000, 26'd0,        -1},    // zero step clears
    '{wdds_pkg::CMD_TICK,  10'd0,    16'h0000, 26'd0,        1711},
    '{wdds_pkg::CMD_STEP,  10'd0,    16'h0000, 26'h3FFFFFF,  -1},    // saturates
    '{wdds_pkg::CMD_TICK,  10'd0,    16'h0000, 26'd0,        688},
    '{wdds_pkg::CMD_TICK,  10'd0,    16'h0000, 26'd0,        688},   // wraps, slot 999
    '{wdds_pkg::CMD_STEP,  10'd0,    16'h0000, 26'd65536000, -1},    // exactly the span
    '{wdds_pkg::CMD_TICK,  10'd0,    16'h0000, 26'd0,        688},
    '{wdds_pkg::CMD_STEP,  10'd0,    16'h0000, 26'd65535999, -1},
    '{wdds_pkg::CMD_TICK,  10'd0,    16'h0000, 26'd0,        688},
    '{CMD_UNUSED,          10'd1023, 16'hFFFF, 26'h3FFFFFF,  -1},    // no effect, no word
    '{wdds_pkg::CMD_STEP,  10'd0,    16'h0000, 26'd1,        -1},
    '{wdds_pkg::CMD_TICK,  10'd0,    16'h0000, 26'd0,        -1},
    '{wdds_pkg::CMD_STEP,  10'd0,    16'h0000, 26'd0,        -1},
    '{wdds_pkg::CMD_STEP,  10'd0,    16'h0000, 26'd65536,    -1},    // one slot per tick
    '{wdds_pkg::CMD_TICK,  10'd0,    16'h0000, 26'd0,        1200},  // slot 1 holds zero
    '{wdds_pkg::CMD_WRITE, 10'd2,    16'h4000, 26'd0,        -1},
    '{wdds_pkg::CMD_TICK,  10'd0,    16'h0000, 26'd0,        -1}
  };

  // Gain settings of the random phases: both extremes, the smallest nonzero
  // gain, two random ones and the reset value written back.
  logic [wdds_pkg::GAIN_W-1:0] phase_gains [6];

  initial begin
    phase_gains = '{16'hFFFF, 16'h0000, 16'h0001, wdds_pkg::GAIN_W'($urandom),
                    wdds_pkg::GAIN_W'($urandom), wdds_pkg::GAIN_RESET};
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_word(1'b0, directed_rows[i]);

    foreach (phase_gains[p]) begin
      wait_idle();
      load_gain(phase_gains[p]);
      @(posedge clk_i);
      repeat (PHASE_WORDS) send_word(1'b1, directed_rows[0]);
    end

    wait_idle();
    if (pending_levels.size() != 0) begin
      $error("pwm_level: %0d expected words never arrived", pending_levels.size());
      errors++;
    end
    if (errors == 0) begin
      $display("wavetable_dds_pwm_sample: match");
    end else begin
      $display("wavetable_dds_pwm_sample: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("wavetable_dds_pwm_sample: mismatch");
    $finish;
  end

endmodule
